// ===== design/i2cm_pkg.sv =====
// Shared types, constants and the transaction program table of the I2C ADC/DAC master.
package i2cm_pkg;

  // Phase counter width; the longest program has ten segments.
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] AdcLen = 4'd10;
  localparam logic [PhaseW-1:0] DacLen = 4'd5;

  // Configuration reset values.
  localparam logic [6:0] DevAddrRst  = 7'd72;
  localparam logic [3:0] AckLimitRst = 4'd5;
  localparam logic [7:0] GapCmdRst   = 8'd10;
  localparam logic [7:0] GapReadRst  = 8'd100;

  // Fixed control byte of the converter: analog output enable.
  localparam logic [7:0] CtrlByte = 8'h40;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEV_ADDR  = 2'd0,
    CFG_ACK_LIMIT = 2'd1,
    CFG_GAP_CMD   = 2'd2,
    CFG_GAP_READ  = 2'd3
  } cfg_idx_e;

  // Bus segments that make up a transaction, one-hot coded.
  typedef enum logic [8:0] {
    SEG_START = 9'b000000001,
    SEG_STOP  = 9'b000000010,
    SEG_WADDR = 9'b000000100,
    SEG_WCTRL = 9'b000001000,
    SEG_WVAL  = 9'b000010000,
    SEG_RADDR = 9'b000100000,
    SEG_READ  = 9'b001000000,
    SEG_GAPC  = 9'b010000000,
    SEG_GAPR  = 9'b100000000
  } seg_e;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [6:0] device_address;
    logic [3:0] ack_poll_limit;
    logic [7:0] gap_after_command;
    logic [7:0] gap_after_read;
  } cfg_t;

  // One request tick.
  typedef struct packed {
    logic       start_request;
    logic       command;
    logic [1:0] channel;
    logic [7:0] dac_value;
    logic       sda_in;
  } req_t;

  // One result tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       error_flag;
    logic [7:0] adc_value;
    logic [1:0] adc_channel;
  } res_t;

  // Segment at a program position; positions past the end read as a stop.
  function automatic seg_e seg_at(logic op, logic [PhaseW-1:0] idx);
    seg_e s;
    s = SEG_STOP;
    if (op) begin
      unique case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_WADDR;
        4'd2:    s = SEG_WCTRL;
        4'd3:    s = SEG_WVAL;
        default: s = SEG_STOP;
      endcase
    end else begin
      unique case (idx)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_WADDR;
        4'd2:    s = SEG_WCTRL;
        4'd3:    s = SEG_STOP;
        4'd4:    s = SEG_GAPC;
        4'd5:    s = SEG_START;
        4'd6:    s = SEG_RADDR;
        4'd7:    s = SEG_READ;
        4'd8:    s = SEG_STOP;
        4'd9:    s = SEG_GAPR;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== design/i2cm_core.sv =====
// Tick sequencer: walks the transaction program and drives the bus pin levels.
module i2cm_core import i2cm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        tick_q, tick_d;
  logic [3:0]        bit_q, bit_d;
  logic [7:0]        shift_q, shift_d;
  logic              op_q, op_d;
  logic [1:0]        ch_q, ch_d;
  logic [7:0]        val_q, val_d;
  logic [7:0]        adc_q [4];
  logic [7:0]        adc_d [4];
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;

  // State as it stands after a possible request has been taken.
  logic              launch;
  logic [PhaseW-1:0] act_phase;
  logic [7:0]        act_tick;
  logic [3:0]        act_bit;

  logic              done, err, adv;
  seg_e              seg, seg_nxt;
  logic [PhaseW-1:0] len, p1, p2;
  logic              skip;
  logic [7:0]        wbyte, dem, gap, gtick;
  logic              fail;

  assign launch    = (phase_q == '0) && req_i.start_request;
  assign act_phase = launch ? 4'd1 : phase_q;
  assign act_tick  = launch ? 8'd0 : tick_q;
  assign act_bit   = launch ? 4'd0 : bit_q;

  // Latches of the request.
  always_comb begin
    op_d  = op_q;
    ch_d  = ch_q;
    val_d = val_q;
    if (launch) begin
      op_d  = req_i.command;
      val_d = req_i.dac_value;
      if (!req_i.command) begin
        ch_d = req_i.channel;
      end
    end
  end

  assign seg = seg_at(op_d, act_phase - 4'd1);
  assign len = op_d ? DacLen : AdcLen;

  // Byte that the current write segment shifts out.
  always_comb begin
    priority if (seg == SEG_WADDR) begin
      wbyte = {cfg_i.device_address, 1'b0};
    end else if (seg == SEG_RADDR) begin
      wbyte = {cfg_i.device_address, 1'b1};
    end else if (seg == SEG_WCTRL) begin
      wbyte = op_d ? CtrlByte : (CtrlByte | {6'd0, ch_d});
    end else begin
      wbyte = val_d;
    end
  end

  assign dem   = act_tick - 8'd2;
  assign fail  = dem >= {4'd0, cfg_i.ack_poll_limit};
  assign gap   = (seg == SEG_GAPC) ? cfg_i.gap_after_command : cfg_i.gap_after_read;
  assign gtick = (act_tick < 8'd255) ? act_tick + 8'd1 : act_tick;

  // Next program position, skipping a gap segment that is configured to zero.
  assign p1      = act_phase + 4'd1;
  assign p2      = act_phase + 4'd2;
  assign seg_nxt = seg_at(op_d, act_phase);
  assign skip    = ((seg_nxt == SEG_GAPC) && (cfg_i.gap_after_command == 8'd0)) ||
                   ((seg_nxt == SEG_GAPR) && (cfg_i.gap_after_read == 8'd0));

  // One tick of the current segment.
  always_comb begin
    phase_d = act_phase;
    tick_d  = act_tick;
    bit_d   = act_bit;
    shift_d = shift_q;
    adc_d   = adc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;
    err     = 1'b0;
    adv     = 1'b0;

    if (act_phase != '0) begin
      unique case (seg)
        SEG_START: begin
          priority if (act_tick == 8'd0) sda_d = 1'b1;
          else if (act_tick == 8'd1) scl_d = 1'b1;
          else if (act_tick == 8'd2) sda_d = 1'b0;
          else begin
            scl_d = 1'b0;
            adv   = 1'b1;
          end
          tick_d = act_tick + 8'd1;
        end
        SEG_STOP: begin
          priority if (act_tick == 8'd0) scl_d = 1'b0;
          else if (act_tick == 8'd1) sda_d = 1'b0;
          else if (act_tick == 8'd2) scl_d = 1'b1;
          else begin
            sda_d = 1'b1;
            adv   = 1'b1;
          end
          tick_d = act_tick + 8'd1;
        end
        SEG_READ: begin
          tick_d = act_tick + 8'd1;
          priority if (act_tick == 8'd0) begin
            sda_d   = 1'b1;
            shift_d = 8'd0;
          end else if (act_tick <= 8'd16) begin
            if (act_tick[0]) begin
              scl_d   = 1'b1;
              shift_d = {shift_q[6:0], req_i.sda_in};
            end else begin
              scl_d = 1'b0;
            end
          end else if (act_tick == 8'd17) begin
            sda_d = 1'b1;
          end else if (act_tick == 8'd18) begin
            scl_d = 1'b1;
          end else begin
            scl_d       = 1'b0;
            adc_d[ch_d] = shift_q;
            adv         = 1'b1;
          end
        end
        SEG_GAPC, SEG_GAPR: begin
          tick_d = gtick;
          adv    = gtick >= gap;
        end
        SEG_WADDR, SEG_WCTRL, SEG_WVAL, SEG_RADDR: begin
          if (!act_bit[3]) begin
            // Data bit: set SDA, raise SCL, lower SCL.
            priority if (act_tick == 8'd0) begin
              sda_d  = wbyte[3'd7 - act_bit[2:0]];
              tick_d = 8'd1;
            end else if (act_tick == 8'd1) begin
              scl_d  = 1'b1;
              tick_d = 8'd2;
            end else begin
              scl_d  = 1'b0;
              bit_d  = act_bit + 4'd1;
              tick_d = 8'd0;
            end
          end else begin
            // Acknowledge: release SDA, raise SCL, then poll.
            priority if (act_tick == 8'd0) begin
              sda_d  = 1'b1;
              tick_d = 8'd1;
            end else if (act_tick == 8'd1) begin
              scl_d  = 1'b1;
              tick_d = 8'd2;
            end else if (fail || !req_i.sda_in) begin
              scl_d = 1'b0;
              if (fail && ((seg == SEG_WADDR) || (seg == SEG_RADDR))) begin
                phase_d = '0;
                done    = 1'b1;
                err     = 1'b1;
                tick_d  = 8'd0;
                bit_d   = 4'd0;
              end else begin
                adv = 1'b1;
              end
            end else begin
              tick_d = act_tick + 8'd1;
            end
          end
        end
        default: ;
      endcase

      // Move on to the next segment or finish.
      if (adv) begin
        tick_d = 8'd0;
        bit_d  = 4'd0;
        priority if (p1 > len) begin
          phase_d = '0;
          done    = 1'b1;
        end else if (skip && (p2 > len)) begin
          phase_d = '0;
          done    = 1'b1;
        end else if (skip) begin
          phase_d = p2;
        end else begin
          phase_d = p1;
        end
      end
    end
  end

  // Result of this tick, taken from the state it leaves behind.
  always_comb begin
    res_o.scl_out     = scl_d;
    res_o.sda_out     = sda_d;
    res_o.busy_res    = phase_d != '0;
    res_o.done_res    = done;
    res_o.error_flag  = err;
    res_o.adc_value   = adc_d[ch_d];
    res_o.adc_channel = ch_d;
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      op_q    <= 1'b0;
      ch_q    <= '0;
      val_q   <= '0;
      adc_q   <= '{default: '0};
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      ch_q    <= ch_d;
      val_q   <= val_d;
      adc_q   <= adc_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  // The program counter never runs past the longer program.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= AdcLen)
    else $error("phase counter out of range");

  // An error is only reported as part of a finishing tick.
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.error_flag |-> res_o.done_res)
    else $error("error without done");

  // A finishing tick leaves the block idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == '0)
    else $error("done while still busy");

  // An aborted transaction leaves SCL low and SDA released.
  a_abort_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.error_flag |=> !scl_q && sda_q)
    else $error("abort left the bus in the wrong state");

endmodule

// ===== design/i2c_adc_dac_transaction_master.sv =====
// Top level of the bit-level I2C master for an ADC/DAC converter.
//
// Usage: every transfer on the slave stream is one bus tick. It carries a start
// request with its command, channel and DAC byte, plus the sampled SDA level.
// Each tick produces exactly one transfer on the master stream with the SCL and
// SDA pin levels, busy, done, error and the stored ADC byte of the latched
// channel. A request is taken only when idle and ignored while busy.
// The result of a tick is registered and presented in the cycle after its transfer.
// Throughput: one tick per cycle while results are taken; the next-state logic of the sequencer sits
// between the accepted tick and the result register.
// A new tick is accepted while the result register is empty or being taken, so
// a stalled receiver holds the result and stops input after one tick.
// Configuration: registers are written over the cfg channel (always ready),
// index 0 device address, 1 acknowledge poll limit, 2 gap after the control
// write, 3 gap after the read. Write them only while the block is idle.
// Reset: the bus is released (SCL and SDA high), the sequencer is idle, the
// stored ADC bytes are zero and the registers take their default values.
module i2c_adc_dac_transaction_master import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] start_request, [2:1] channel, [10:3] dac_value, [11] sda_in, [15:12] zero
  input  logic [15:0] s_axis_tdata_i,
  // [0] command
  input  logic        s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] error_flag,
  // [12:5] adc_value, [14:13] adc_channel, [15] zero
  output logic [15:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t        cfg_q;
  req_t        req;
  res_t        res;
  logic        step;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= DevAddrRst;
      cfg_q.ack_poll_limit    <= AckLimitRst;
      cfg_q.gap_after_command <= GapCmdRst;
      cfg_q.gap_after_read    <= GapReadRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_DEV_ADDR:  cfg_q.device_address    <= cfg_data_i[6:0];
        CFG_ACK_LIMIT: cfg_q.ack_poll_limit    <= cfg_data_i[3:0];
        CFG_GAP_CMD:   cfg_q.gap_after_command <= cfg_data_i;
        CFG_GAP_READ:  cfg_q.gap_after_read    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the tick.
  assign req.start_request = s_axis_tdata_i[0];
  assign req.command       = s_axis_tuser_i;
  assign req.channel       = s_axis_tdata_i[2:1];
  assign req.dac_value     = s_axis_tdata_i[10:3];
  assign req.sda_in        = s_axis_tdata_i[11];

  // A tick is taken whenever the result register can take its result.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, res.adc_channel, res.adc_value, res.error_flag,
                     res.done_res, res.busy_res, res.sda_out, res.scl_out};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
